@@ sv/smfu_pkg.sv @@
// Package for the SGD matrix factor update block.
// Holds table sizes, function codes, register indexes, Q8.24 helpers. No dependencies.
package smfu_pkg;

	localparam int unsigned QSHIFT = 24;

	// table geometry: rows of each table and features per row
	localparam int unsigned USER_ROWS    = 4096;
	localparam int unsigned ITEM_ROWS    = 4096;
	localparam int unsigned MAX_FEATURES = 64;

	typedef enum logic [2:0] {
		FN_LOAD_USER = 3'd0,
		FN_LOAD_ITEM = 3'd1,
		FN_TRAIN     = 3'd2,
		FN_READ_USER = 3'd3,
		FN_READ_ITEM = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		REG_LR       = 3'd0,
		REG_RC       = 3'd1,
		REG_NC       = 3'd2,
		REG_MODE     = 3'd3,
		REG_FCOUNT   = 3'd4
	} reg_idx_t;

	localparam logic [1:0] MODE_DIFF = 2'd1;
	localparam logic [1:0] MODE_SIGN = 2'd2;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	// saturate a 48-bit signed value to 32 bits
	function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'(S32_MAX);
		lo = 48'(S32_MIN);
		if (x > hi) return S32_MAX;
		if (x < lo) return S32_MIN;
		return x[31:0];
	endfunction

	// round a 66-bit product to nearest Q8.24 (ties up), then saturate
	function automatic logic signed [31:0] qround(input logic signed [65:0] p);
		logic signed [65:0] r;
		logic signed [41:0] s;
		r = p + 66'sd8388608;
		s = 42'(r >>> QSHIFT);
		if (s > 42'sd2147483647) return S32_MAX;
		if (s < -42'sd2147483648) return S32_MIN;
		return s[31:0];
	endfunction

endpackage

@@ sv/smfu_if.sv @@
// Valid/ready channel interface, payload type given by parameter.
// Depends on nothing.
interface smfu_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/smfu_qmul.sv @@
// Registered Q8.24 multiplier: 33x33 product, then round and saturate.
// Depends on smfu_pkg.
module smfu_qmul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [31:0] y
);
	logic signed [65:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign y = smfu_pkg::qround(prod_s1);
endmodule

@@ sv/smfu_ram.sv @@
// Single-port synchronous factor memory with registered read.
// Depends on nothing.
module smfu_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ sv/sgd_matrix_factor_update.sv @@
// SGD matrix factor update. Two single-port factor memories (user, item) hold
// Q8.24 rows of MAX_FEATURES elements. A load writes one element and gives no
// result; a read registers its result through the memory and output states. Train
// makes two passes over the features in use (n): the dot-product pass streams one
// element pair per cycle through a registered multiplier, the error step forms
// the prediction error and the novelty product, then the update pass reads each
// pair again and runs seven products through one shared multiplier before writing
// both elements back. With no features in use the train result is given straight
// after the error step. Results sit in an output register until taken.
// Entries never loaded read back as whatever the memory holds.
module sgd_matrix_factor_update (
	input  logic clk,
	input  logic arst_n,
	smfu_if.sink   in_ch,
	smfu_if.sink   cfg,
	smfu_if.source out_ch
);
	localparam int unsigned USER_ROWS    = smfu_pkg::USER_ROWS;
	localparam int unsigned ITEM_ROWS    = smfu_pkg::ITEM_ROWS;
	localparam int unsigned MAX_FEATURES = smfu_pkg::MAX_FEATURES;
	localparam int unsigned FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int unsigned URW = (USER_ROWS > 1) ? $clog2(USER_ROWS) : 1;
	localparam int unsigned IRW = (ITEM_ROWS > 1) ? $clog2(ITEM_ROWS) : 1;
	localparam int unsigned UAW = URW + FW;
	localparam int unsigned IAW = IRW + FW;
	localparam int unsigned CW  = $clog2(MAX_FEATURES + 1);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MEM   = 10'b0000000010,
		ST_DOT   = 10'b0000000100,
		ST_ERR   = 10'b0000001000,
		ST_URD   = 10'b0000010000,
		ST_M1    = 10'b0000100000,
		ST_M2    = 10'b0001000000,
		ST_M3    = 10'b0010000000,
		ST_M4    = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// config
	logic [24:0] lr_q, rc_q, nc_q;
	logic [1:0]  mode_q;
	logic [6:0]  fcount_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q     <= 25'd167772;
			rc_q     <= 25'd335544;
			nc_q     <= 25'd0;
			mode_q   <= 2'd0;
			fcount_q <= 7'd64;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				smfu_pkg::REG_LR:     lr_q     <= cfg.data.value[24:0];
				smfu_pkg::REG_RC:     rc_q     <= cfg.data.value[24:0];
				smfu_pkg::REG_NC:     nc_q     <= cfg.data.value[24:0];
				smfu_pkg::REG_MODE:   mode_q   <= cfg.data.value[1:0];
				smfu_pkg::REG_FCOUNT: fcount_q <= cfg.data.value[6:0];
				default: ;
			endcase
		end
	end

	// latched request
	logic [2:0]         func_q;
	logic [URW-1:0]     urow_q;
	logic [IRW-1:0]     irow_q;
	logic [FW-1:0]      feat_q;
	logic signed [31:0] score_q, nov_q, load_q;

	// sequencing
	logic [CW-1:0] n_q;        // features in use
	logic [CW-1:0] rd_cnt_q;   // dot pass issue count
	logic [CW-1:0] ac_cnt_q;   // dot pass accumulate count
	logic          rd_v_s1, mul_v_s2;
	logic [FW-1:0] upd_f_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] pred_q, err_q, cn_q;
	logic signed [31:0] u_q, v_q;
	logic               cn_done_q;

	// memories
	logic           u_we, i_we;
	logic [UAW-1:0] u_addr;
	logic [IAW-1:0] i_addr;
	logic [31:0]    u_wdata, i_wdata, u_rdata, i_rdata;
	logic [FW-1:0]  f_sel;

	smfu_ram #(.DEPTH(USER_ROWS * MAX_FEATURES), .AW(UAW)) u_mem (
		.clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata));
	smfu_ram #(.DEPTH(ITEM_ROWS * MAX_FEATURES), .AW(IAW)) i_mem (
		.clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(i_rdata));

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [31:0] mul_y;
	smfu_qmul mul (.clk(clk), .a(mul_a), .b(mul_b), .y(mul_y));

	// row wrap: row % ROWS
	function automatic logic [URW-1:0] uwrap(input logic [11:0] r);
		logic [11:0] m;
		m = 12'(32'(r) % USER_ROWS);
		return URW'(m);
	endfunction
	function automatic logic [IRW-1:0] iwrap(input logic [11:0] r);
		logic [11:0] m;
		m = 12'(32'(r) % ITEM_ROWS);
		return IRW'(m);
	endfunction

	// feature column in use this cycle
	always_comb begin
		f_sel = feat_q;
		if (state_q == ST_DOT) f_sel = rd_cnt_q[FW-1:0];
		else if (state_q != ST_MEM) f_sel = upd_f_q;
	end

	assign u_addr = {urow_q, f_sel};
	assign i_addr = {irow_q, f_sel};

	// update datapath helpers
	logic signed [32:0] diff33;
	logic signed [31:0] diff_sat, nt_sign;
	always_comb begin
		diff33   = 33'(u_q) - 33'(v_q);
		diff_sat = smfu_pkg::sat48(48'(diff33));
		if (diff33 > 0)      nt_sign = cn_q;
		else if (diff33 < 0) nt_sign = smfu_pkg::sat48(-48'(cn_q));
		else                 nt_sign = 32'sd0;
	end

	// step counter inside the update sequence of one feature
	logic [2:0] sub_q;
	logic signed [31:0] nt_q, eu_q, ev_q, rv_q, ru_q;
	logic signed [31:0] dv_sat, du_sat;
	always_comb begin
		dv_sat = smfu_pkg::sat48(48'(eu_q) + 48'(eu_q) - 48'(rv_q) - 48'(nt_q));
		du_sat = smfu_pkg::sat48(48'(ev_q) + 48'(ev_q) - 48'(ru_q) - 48'(nt_q));
	end

	// multiplier operand select per step
	always_comb begin
		mul_a = 33'(u_rdata[31:0]);
		mul_b = 33'($signed(i_rdata));
		unique case (state_q)
			ST_ERR: begin
				mul_a = 33'(nc_q);
				mul_b = 33'(nov_q);
			end
			ST_M1, ST_M2, ST_M3, ST_M4: begin
				unique case (sub_q)
					3'd0: begin mul_a = 33'(err_q); mul_b = 33'(u_q); end
					3'd1: begin mul_a = 33'(err_q); mul_b = 33'(v_q); end
					3'd2: begin mul_a = 33'(rc_q);  mul_b = 33'(v_q); end
					3'd3: begin mul_a = 33'(rc_q);  mul_b = 33'(u_q); end
					3'd4: begin mul_a = 33'(diff_sat); mul_b = 33'(cn_q); end
					3'd5: begin mul_a = 33'(lr_q);  mul_b = 33'(dv_sat); end
					3'd6: begin mul_a = 33'(lr_q);  mul_b = 33'(du_sat); end
					default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
				endcase
			end
			default: begin
				mul_a = 33'($signed(u_rdata));
				mul_b = 33'($signed(i_rdata));
			end
		endcase
	end

	// write-back values
	logic signed [31:0] v_new_q;
	always_comb begin
		u_we    = 1'b0;
		i_we    = 1'b0;
		u_wdata = load_q;
		i_wdata = load_q;
		if (state_q == ST_MEM && func_q == smfu_pkg::FN_LOAD_USER) u_we = 1'b1;
		if (state_q == ST_MEM && func_q == smfu_pkg::FN_LOAD_ITEM) i_we = 1'b1;
		if (state_q == ST_M4) begin
			u_we    = 1'b1;
			i_we    = 1'b1;
			u_wdata = smfu_pkg::sat48(48'(u_q) + 48'(mul_y));
			i_wdata = v_new_q;
		end
	end

	// output register
	typedef struct packed {
		logic signed [31:0] prediction;
		logic [30:0]        abs_error;
		logic signed [31:0] read_value;
	} res_t;
	res_t res_q;
	logic out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_q;

	assign in_ch.ready = (state_q == ST_IDLE) && !out_v_q;

	logic signed [32:0] err33;
	logic signed [31:0] err_sat;
	always_comb begin
		err33   = 33'(score_q) - 33'(smfu_pkg::sat48(acc_q));
		err_sat = smfu_pkg::sat48(48'(err33));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_v_q  <= 1'b0;
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
			sub_q    <= 3'd0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						func_q  <= in_ch.data.func;
						urow_q  <= uwrap(in_ch.data.user_index);
						irow_q  <= iwrap(in_ch.data.item_index);
						feat_q  <= FW'(32'(in_ch.data.feature_index) % MAX_FEATURES);
						score_q <= in_ch.data.score;
						nov_q   <= in_ch.data.novelty;
						load_q  <= in_ch.data.load_value;
						n_q     <= (fcount_q > 7'(MAX_FEATURES)) ? CW'(MAX_FEATURES)
							: CW'(fcount_q);
						rd_cnt_q <= '0;
						ac_cnt_q <= '0;
						acc_q    <= 48'sd0;
						upd_f_q  <= '0;
						rd_v_s1  <= 1'b0;
						mul_v_s2 <= 1'b0;
						cn_done_q <= 1'b0;
						if (in_ch.data.func == smfu_pkg::FN_TRAIN) state_q <= ST_DOT;
						else if (in_ch.data.func <= smfu_pkg::FN_READ_ITEM) state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					// load writes here; read data is valid next cycle
					if (func_q == smfu_pkg::FN_READ_USER || func_q == smfu_pkg::FN_READ_ITEM)
						state_q <= ST_OUT;
					else state_q <= ST_IDLE;
				end
				ST_OUT: begin
					res_q.prediction <= 32'sd0;
					res_q.abs_error  <= 31'd0;
					res_q.read_value <= (func_q == smfu_pkg::FN_READ_USER) ? u_rdata : i_rdata;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DOT: begin
					// issue read, then multiply, then accumulate
					rd_v_s1  <= (rd_cnt_q < n_q);
					if (rd_cnt_q < n_q) rd_cnt_q <= rd_cnt_q + 1'b1;
					mul_v_s2 <= rd_v_s1;
					if (mul_v_s2) begin
						acc_q    <= acc_q + 48'(mul_y);
						ac_cnt_q <= ac_cnt_q + 1'b1;
					end
					if (ac_cnt_q == n_q && !rd_v_s1 && !mul_v_s2 && rd_cnt_q == n_q)
						state_q <= ST_ERR;
				end
				ST_ERR: begin
					// first visit loads operands, the next takes the novelty product
					if (!cn_done_q) begin
						cn_done_q <= 1'b1;
						pred_q    <= smfu_pkg::sat48(acc_q);
						err_q     <= err_sat;
					end else begin
						cn_q <= mul_y;
						res_q.prediction <= pred_q;
						res_q.abs_error  <= (err_q == smfu_pkg::S32_MIN) ? 31'h7fffffff
							: 31'(err_q < 0 ? -err_q : err_q);
						res_q.read_value <= 32'sd0;
						if (n_q == '0) begin
							out_v_q <= 1'b1;
							state_q <= ST_IDLE;
						end else state_q <= ST_URD;
					end
				end
				ST_URD: begin
					// read issued this cycle for upd_f_q
					state_q <= ST_M1;
					sub_q   <= 3'd7;
				end
				ST_M1: begin
					// capture operands, then step the multiplier through products
					if (sub_q == 3'd7) begin
						u_q   <= u_rdata;
						v_q   <= i_rdata;
						sub_q <= 3'd0;
					end else begin
						sub_q <= sub_q + 3'd1;
						state_q <= ST_M2;
					end
				end
				ST_M2: begin
					// result of previous step is on mul_y
					unique case (sub_q)
						3'd1: eu_q <= mul_y;
						3'd2: ev_q <= mul_y;
						3'd3: rv_q <= mul_y;
						3'd4: ru_q <= mul_y;
						3'd5: begin
							if (mode_q == smfu_pkg::MODE_DIFF) nt_q <= mul_y;
							else if (mode_q == smfu_pkg::MODE_SIGN) nt_q <= nt_sign;
							else nt_q <= 32'sd0;
						end
						3'd6: v_new_q <= smfu_pkg::sat48(48'(v_q) + 48'(mul_y));
						default: ;
					endcase
					state_q <= ST_M3;
				end
				ST_M3: begin
					// sub_q selects next product once the multiplier register holds the current one
					if (sub_q == 3'd6) state_q <= ST_M4;
					else begin
						sub_q   <= sub_q + 3'd1;
						state_q <= ST_M2;
					end
				end
				ST_M4: begin
					// mul_y holds lr*du; both rows written this cycle
					if (CW'(upd_f_q) + 1'b1 == n_q) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						upd_f_q <= upd_f_q + 1'b1;
						state_q <= ST_URD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
